@@ rtl/svm_pkg.sv @@
// Shared types, constants and helpers for the stack machine instruction unit.
// Depends on nothing; imported by stack_vm_instruction_unit and tb_top.
package svm_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int PTR_W       = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = PTR_W;
	localparam int WORD_W      = 16;
	localparam int OPC_W       = 4;
	localparam int STAT_W      = 2;
	localparam int DEPTH_W     = 4;

	typedef enum logic [OPC_W-1:0] {
		OP_NOP   = 4'd0,
		OP_PUSH  = 4'd1,
		OP_SECT  = 4'd2,
		OP_JUMP  = 4'd3,
		OP_JSEQ  = 4'd4,
		OP_JSNE  = 4'd5,
		OP_JSGE  = 4'd6,
		OP_SJUMP = 4'd7,
		OP_SRET  = 4'd8,
		OP_SPOP  = 4'd9,
		OP_SADD  = 4'd10
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_STACK  = 2'd1,
		ST_UNIMPL = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Ring index base + off, both below STACK_DEPTH.
	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
		input logic [PTR_W-1:0] off);
		logic [PTR_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (PTR_W+1)'(STACK_DEPTH))
			s = s - (PTR_W+1)'(STACK_DEPTH);
		return s[PTR_W-1:0];
	endfunction

endpackage

@@ rtl/stack_vm_instruction_unit.sv @@
// Top level of the stack machine instruction unit: control, stack memory and
// execute logic. Depends on svm_pkg.

// Executes one instruction of a small 16-bit stack machine per input
// transaction (opcode and signed immediate) and returns one result
// transaction with the next program counter, a status code and the stack
// depth. In the cycle an instruction is accepted the stack memory is read at
// the top two ring slots (or at the bottom slot for a return), and in the
// execute state the registered read data is used to execute, write back to
// the memory and update the program counter, count and bottom pointer. The
// unit takes no new instruction until the previous one has executed, as the
// stack memory read is registered; a result still waiting at the output
// delays the execute cycle of the following instruction until it is taken.
// The stack is a ring deque of STACK_DEPTH words holding at most
// STACK_DEPTH-1 entries; pushes and pops act at the top while calls insert
// the return address at the bottom. The memory needs no clearing after
// reset, since only entries on the stack are ever used. Any error (status 1
// or 2) leaves all state unchanged and reports the current program counter
// and depth.
module stack_vm_instruction_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [svm_pkg::OPC_W-1:0]        req_type,
	input  logic signed [svm_pkg::WORD_W-1:0] immediate,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [svm_pkg::WORD_W-1:0]       next_pc,
	output logic [svm_pkg::STAT_W-1:0]       status,
	output logic [svm_pkg::DEPTH_W-1:0]      depth
);
	import svm_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(STACK_DEPTH - 1);
	localparam logic [PTR_W-1:0] MAX_PTR = PTR_W'(STACK_DEPTH - 1);

	// Architectural state.
	logic [WORD_W-1:0] pc_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  bottom_q;
	state_t            state_q, state_d;

	// Instruction captured at acceptance, and the registered memory reads.
	op_t               op_s1;
	logic [WORD_W-1:0] imm_s1;
	logic [WORD_W-1:0] rd_top_s1;
	logic [WORD_W-1:0] rd_next_s1;

	// Output register.
	logic              out_valid_q;
	logic [WORD_W-1:0] next_pc_q;
	status_t           status_q;
	logic [DEPTH_W-1:0] depth_q;

	logic              accept;
	logic              exec_done;
	logic [CNT_W-1:0]  cnt_m1, cnt_m2;
	logic [PTR_W-1:0]  raddr_top, raddr_next;

	// Execute results.
	logic [WORD_W-1:0] pc_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [PTR_W-1:0]  bot_n;
	status_t           st_n;
	logic              we;
	logic [PTR_W-1:0]  waddr;
	logic [WORD_W-1:0] wdata;

	logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

	assign cnt_m1 = count_q - CNT_W'(1);
	assign cnt_m2 = cnt_m1 - CNT_W'(1);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (!out_valid_q || out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready  = 1'b0;
		exec_done = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_EXEC: exec_done = !out_valid_q || out_ready;
			default: begin
				in_ready  = 1'b0;
				exec_done = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// A return reads the bottom slot; everything else reads the top two.
	assign raddr_top  = (op_t'(req_type) == OP_SRET) ? bottom_q : ring_add(bottom_q, cnt_m1);
	assign raddr_next = ring_add(bottom_q, cnt_m2);

	// Stack memory: one write port, two registered read ports. Writes land at
	// the execute edge, so the next instruction's reads already see them.
	always_ff @(posedge clk) begin
		if (we)
			stack_mem[waddr] <= wdata;
		if (accept) begin
			rd_top_s1  <= stack_mem[raddr_top];
			rd_next_s1 <= stack_mem[raddr_next];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(req_type);
			imm_s1 <= immediate;
		end
	end

	// Execute: decode the captured instruction against the current state.
	always_comb begin
		logic [WORD_W-1:0] pc4;
		logic              cond;
		pc4   = pc_q + WORD_W'(4);
		cond  = 1'b0;
		pc_n  = pc4;
		cnt_n = count_q;
		bot_n = bottom_q;
		st_n  = ST_OK;
		we    = 1'b0;
		waddr = ring_add(bottom_q, count_q);
		wdata = imm_s1;
		case (op_s1)
			OP_NOP: pc_n = pc4;
			OP_PUSH: begin
				if (count_q == MAX_CNT) begin
					st_n = ST_STACK;
				end else begin
					we    = 1'b1;
					cnt_n = count_q + CNT_W'(1);
				end
			end
			OP_SECT: pc_n = pc_q + WORD_W'(2);
			OP_JUMP: pc_n = imm_s1;
			OP_JSEQ, OP_JSNE, OP_JSGE: begin
				if (count_q <= CNT_W'(1)) begin
					st_n = ST_STACK;
				end else begin
					// The deeper value stays in its slot; only the top goes.
					if (op_s1 == OP_JSEQ)
						cond = (rd_next_s1 == rd_top_s1);
					else if (op_s1 == OP_JSNE)
						cond = (rd_next_s1 != rd_top_s1);
					else
						cond = ($signed(rd_next_s1) >= $signed(rd_top_s1));
					cnt_n = cnt_m1;
					pc_n  = cond ? imm_s1 : pc4;
				end
			end
			OP_SJUMP: begin
				if (count_q == '0) begin
					st_n = ST_STACK;
				end else begin
					// Pop the target and insert the return address at the bottom;
					// the depth stays the same.
					bot_n = (bottom_q == '0) ? MAX_PTR : bottom_q - PTR_W'(1);
					we    = 1'b1;
					waddr = bot_n;
					wdata = pc4;
					pc_n  = rd_top_s1;
				end
			end
			OP_SRET: begin
				if (count_q == '0) begin
					st_n = ST_STACK;
				end else begin
					pc_n  = rd_top_s1;
					bot_n = ring_add(bottom_q, PTR_W'(1));
					cnt_n = cnt_m1;
				end
			end
			OP_SPOP: begin
				if (count_q == '0)
					st_n = ST_STACK;
				else
					cnt_n = cnt_m1;
			end
			OP_SADD: begin
				if (count_q <= CNT_W'(1)) begin
					st_n = ST_STACK;
				end else begin
					we    = 1'b1;
					waddr = ring_add(bottom_q, cnt_m2);
					wdata = rd_top_s1 + rd_next_s1;
					cnt_n = cnt_m1;
				end
			end
			default: st_n = ST_UNIMPL;
		endcase
		if (st_n != ST_OK) begin
			pc_n  = pc_q;
			cnt_n = count_q;
			bot_n = bottom_q;
			we    = 1'b0;
		end
		we = we && exec_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			count_q     <= '0;
			bottom_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_done) begin
				pc_q        <= pc_n;
				count_q     <= cnt_n;
				bottom_q    <= bot_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_done) begin
			next_pc_q <= pc_n;
			status_q  <= st_n;
			depth_q   <= DEPTH_W'(cnt_n);
		end
	end

	assign out_valid = out_valid_q;
	assign next_pc   = next_pc_q;
	assign status    = status_q;
	assign depth     = depth_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("stack count beyond capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted instruction not executed next");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_done |=> ($stable(pc_q) && $stable(count_q) && $stable(bottom_q)))
		else $error("state changed outside execute");

	a_error_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_done && st_n != ST_OK) |=>
		($stable(pc_q) && $stable(count_q) && $stable(bottom_q)))
		else $error("failed instruction changed state");

	a_write_exec: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (exec_done && st_n == ST_OK))
		else $error("stack write outside a successful execute");
`endif

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for stack_vm_instruction_unit: directed and random instruction
// streams, with an instruction-level predictor and random stalls on both sides.
// Depends on svm_pkg and the stack_vm_instruction_unit RTL.
`timescale 1ns / 1ps

module tb_top;
	import svm_pkg::*;

	// Random instructions after the directed tests; together they come to about 950.
	localparam int RANDOM_ITEMS = 920;
	// This limit leaves a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT = 100000;
	// Cycles to watch for stray results once every expected result has arrived.
	localparam int SETTLE_CYCLES = 8;

	// Opcodes that the unit does not implement.
	localparam logic [OPC_W-1:0] OP_UNUSED_LO = 4'd11;
	localparam logic [OPC_W-1:0] OP_UNUSED_HI = 4'd15;

	typedef struct {
		logic [WORD_W-1:0]  next_pc;
		status_t            status;
		logic [DEPTH_W-1:0] depth;
	} instr_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [OPC_W-1:0]         req_type = '0;
	logic signed [WORD_W-1:0] immediate = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [WORD_W-1:0]        next_pc;
	logic [STAT_W-1:0]        status;
	logic [DEPTH_W-1:0]       depth;

	// Architectural state of the machine as the predictor sees it. The stack is
	// a ring: stack_base points at the bottom entry, and stack_fill entries
	// follow it upward.
	logic [WORD_W-1:0] pc_reg = '0;
	logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
	int                stack_fill = 0;
	int                stack_base = 0;

	// Results predicted for accepted instructions, oldest first.
	instr_result_t pending_results [$];
	int            mismatch_count = 0;
	int            cycle_count = 0;
	// While set, neither side idles, so the unit runs at full rate.
	bit            steady = 1'b0;

	always #1 clk = ~clk;

	stack_vm_instruction_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.immediate (immediate),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.next_pc   (next_pc),
		.status    (status),
		.depth     (depth)
	);

	// Stack helpers of the predictor; both act at the top of the ring.
	function automatic void push_word(input logic [WORD_W-1:0] value);
		stack_mem[(stack_base + stack_fill) % STACK_DEPTH] = value;
		stack_fill++;
	endfunction

	function automatic logic [WORD_W-1:0] pop_word();
		stack_fill--;
		return stack_mem[(stack_base + stack_fill) % STACK_DEPTH];
	endfunction

	// Executes one instruction on the predicted state and returns the result
	// the unit must report for it. On any error the state stays as it was, and
	// the result carries the current program counter and depth.
	function automatic instr_result_t execute_instr(input logic [OPC_W-1:0] opc,
		input logic [WORD_W-1:0] imm);
		instr_result_t res;
		logic [WORD_W-1:0] pc_seq;
		logic [WORD_W-1:0] target;
		logic [WORD_W-1:0] upper;
		logic [WORD_W-1:0] lower;
		logic taken;
		pc_seq = pc_reg + 16'd4;
		target = pc_reg;
		res.status = ST_OK;
		case (opc)
			OP_NOP: target = pc_seq;
			OP_SECT: target = pc_reg + 16'd2;
			OP_JUMP: target = imm;
			OP_PUSH: begin
				if (stack_fill + 1 >= STACK_DEPTH) begin
					res.status = ST_STACK;
				end else begin
					push_word(imm);
					target = pc_seq;
				end
			end
			OP_JSEQ, OP_JSNE, OP_JSGE: begin
				if (stack_fill < 2) begin
					res.status = ST_STACK;
				end else begin
					upper = pop_word();
					lower = pop_word();
					case (opc)
						OP_JSEQ: taken = (lower == upper);
						OP_JSNE: taken = (lower != upper);
						default: taken = ($signed(lower) >= $signed(upper));
					endcase
					// The deeper operand goes back on the stack, taken or not.
					push_word(lower);
					target = taken ? imm : pc_seq;
				end
			end
			OP_SJUMP: begin
				if (stack_fill < 1) begin
					res.status = ST_STACK;
				end else begin
					target = pop_word();
					// The return address goes in below the bottom entry.
					stack_base = (stack_base + STACK_DEPTH - 1) % STACK_DEPTH;
					stack_mem[stack_base] = pc_seq;
					stack_fill++;
				end
			end
			OP_SRET: begin
				if (stack_fill < 1) begin
					res.status = ST_STACK;
				end else begin
					target = stack_mem[stack_base];
					stack_base = (stack_base + 1) % STACK_DEPTH;
					stack_fill--;
				end
			end
			OP_SPOP: begin
				if (stack_fill < 1) begin
					res.status = ST_STACK;
				end else begin
					void'(pop_word());
					target = pc_seq;
				end
			end
			OP_SADD: begin
				if (stack_fill < 2) begin
					res.status = ST_STACK;
				end else begin
					upper = pop_word();
					lower = pop_word();
					push_word(upper + lower);
					target = pc_seq;
				end
			end
			default: res.status = ST_UNIMPL;
		endcase
		if (res.status == ST_OK)
			pc_reg = target;
		res.next_pc = pc_reg;
		res.depth = DEPTH_W'(stack_fill);
		return res;
	endfunction

	// Sends one instruction transaction (idling at random first unless steady is set) and records its predicted
	// result once the unit has accepted it. Valid stays high afterwards, so back-to-back calls give a gapless
	// stream while steady is set; anything that waits must lower it first.
	task automatic issue_instr(input logic [OPC_W-1:0] opc, input logic [WORD_W-1:0] imm);
		if (!steady && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= opc;
		immediate <= imm;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(execute_instr(opc, imm));
	endtask

	// Stops sending and waits until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Pop, return, call, add and a signed compare jump on the empty stack must each fail and change nothing.
	task automatic test_empty_stack_errors();
		issue_instr(OP_SPOP, 16'h0000);
		issue_instr(OP_SRET, 16'h0000);
		issue_instr(OP_SJUMP, 16'hFFFF);
		issue_instr(OP_SADD, 16'h0000);
		issue_instr(OP_JSGE, 16'h8000);
	endtask

	task automatic test_unknown_opcodes();
		issue_instr(OP_UNUSED_LO, 16'h5555);
		issue_instr(OP_UNUSED_HI, 16'hAAAA);
	endtask

	// Plain control flow, ending with a program counter that wraps past zero.
	task automatic test_flow_ops();
		issue_instr(OP_NOP, 16'h0000);
		issue_instr(OP_SECT, 16'hFFFF);
		issue_instr(OP_JUMP, 16'hFFFE);
		issue_instr(OP_NOP, 16'h7FFF);
	endtask

	// Fills the stack to its limit of STACK_DEPTH-1 entries, then one push too
	// many. The top five entries are chosen for the compare and call test.
	task automatic test_full_stack();
		for (int k = 0; k < STACK_DEPTH - 6; k++)
			issue_instr(OP_PUSH, 16'h0001 << k);
		issue_instr(OP_PUSH, 16'h0005);
		issue_instr(OP_PUSH, 16'h0005);
		issue_instr(OP_PUSH, 16'hFFFF);
		issue_instr(OP_PUSH, 16'h7FFF);
		issue_instr(OP_PUSH, 16'h8000);
		issue_instr(OP_PUSH, 16'h1234);
	endtask

	// Works down the full stack: a signed compare across the sign boundary, a
	// wrapping add, both equality jumps, then a call and a return that move
	// the bottom of the ring across index zero.
	task automatic test_compare_and_call();
		issue_instr(OP_JSGE, 16'h0100);
		issue_instr(OP_SADD, 16'h0000);
		issue_instr(OP_JSNE, 16'h0200);
		issue_instr(OP_JSEQ, 16'hFFFC);
		issue_instr(OP_SJUMP, 16'h0000);
		issue_instr(OP_SRET, 16'h0000);
		drain_results();
	endtask

	function automatic logic [OPC_W-1:0] pick_opcode();
		int r;
		r = $urandom_range(99);
		if (r < 4) return OP_NOP;
		if (r < 8) return OP_SECT;
		if (r < 13) return OP_JUMP;
		if (r < 25) return OP_PUSH;
		if (r < 34) return OP_JSEQ;
		if (r < 43) return OP_JSNE;
		if (r < 52) return OP_JSGE;
		if (r < 61) return OP_SJUMP;
		if (r < 70) return OP_SRET;
		if (r < 79) return OP_SPOP;
		if (r < 92) return OP_SADD;
		return OPC_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
	endfunction

	// Small values make equal operands common; the rest are extremes or random.
	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			case ($urandom_range(3))
				0: return 16'h0000;
				1: return 16'hFFFF;
				2: return 16'h7FFF;
				default: return 16'h8000;
			endcase
		end
		if (r < 4)
			return WORD_W'($urandom_range(3));
		return WORD_W'($urandom);
	endfunction

	// Random programs. A depth goal, redrawn every forty instructions, biases
	// the stream toward pushes until it is reached; the goal is drawn from every
	// depth from empty to full. Part of the run goes with no idling at all, and
	// once the sender holds off until every result is back.
	task automatic test_random_programs();
		int fill_goal;
		logic [OPC_W-1:0] opc;
		fill_goal = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				fill_goal = $urandom_range(STACK_DEPTH - 1, 0);
			steady = (n >= 400 && n < 650);
			if (n == 300)
				drain_results();
			if (stack_fill < fill_goal && $urandom_range(1) == 1)
				opc = OP_PUSH;
			else
				opc = pick_opcode();
			issue_instr(opc, pick_word());
		end
		steady = 1'b0;
	endtask

	// The receiver stalls now and then, except during the steady stretch.
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 6);
	end

	// Checks every result transaction against the oldest prediction.
	always @(posedge clk) begin : check_results
		instr_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: next_pc %h status %0d depth %0d",
					next_pc, status, depth);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (next_pc !== want.next_pc) begin
					$error("next_pc: expected %h, got %h", want.next_pc, next_pc);
					mismatch_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_count++;
				end
				if (depth !== want.depth) begin
					$error("depth: expected %0d, got %0d", want.depth, depth);
					mismatch_count++;
				end
			end
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_stack_errors();
		test_unknown_opcodes();
		test_flow_ops();
		test_full_stack();
		test_compare_and_call();
		test_random_programs();
		drain_results();
		// Any result that turns up now has no instruction behind it.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
